// File: sv/tpg_pkg.sv
// ----------------------------------------------------------------------------
// tpg_pkg
// Shared types and constants for the throttled packet generator.
// ----------------------------------------------------------------------------
package tpg_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int CfgWordW = 32;
  localparam int FlitCntW = 8;
  localparam int PktCntW  = 64;
  localparam int MaskW    = 64;

  localparam logic [CfgWordW-1:0] CreditReset = 32'd1000;

  typedef enum logic [CfgIdxW-1:0] {
    RegPenaltyPerFlit = 3'd0,
    RegCreditPerTick  = 3'd1,
    RegFlitsMinusOne  = 3'd2,
    RegFinalKeepMask  = 3'd3
  } tpg_reg_e;

  typedef struct packed {
    logic [CfgWordW-1:0] penalty_per_flit;
    logic [CfgWordW-1:0] credit_per_tick;
    logic [FlitCntW-1:0] flits_per_packet_minus_one;
    logic [MaskW-1:0]    final_keep_mask;
  } tpg_cfg_t;

endpackage

// File: sv/tpg_in_if.sv
// ----------------------------------------------------------------------------
// tpg_in_if
// Tick channel: one word per tick, carrying the downstream ready flag.
// ----------------------------------------------------------------------------
interface tpg_in_if;
  logic valid;
  logic ready;
  logic sink_ready;

  modport source (output valid, output sink_ready, input ready);
  modport sink (input valid, input sink_ready, output ready);
endinterface

// File: sv/tpg_out_if.sv
// ----------------------------------------------------------------------------
// tpg_out_if
// Result channel: one word per tick with flit flags, keep and counters.
// ----------------------------------------------------------------------------
interface tpg_out_if #(
  parameter int KEEP_BITS = 64
);
  logic                 valid;
  logic                 ready;
  logic                 flit_valid;
  logic                 flit_last;
  logic [KEEP_BITS-1:0] flit_keep;
  logic [63:0]          packet_index;
  logic [63:0]          packets_sent;

  modport source (
    output valid, output flit_valid, output flit_last, output flit_keep,
    output packet_index, output packets_sent, input ready
  );
  modport sink (
    input valid, input flit_valid, input flit_last, input flit_keep,
    input packet_index, input packets_sent, output ready
  );
endinterface

// File: sv/tpg_cfg_regs.sv
// ----------------------------------------------------------------------------
// tpg_cfg_regs
// Configuration register bank, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module tpg_cfg_regs (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [tpg_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tpg_pkg::CfgDataW-1:0] cfg_data_i,
  output tpg_pkg::tpg_cfg_t        cfg_o
);
  import tpg_pkg::*;

  tpg_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (tpg_reg_e'(cfg_idx_i))
        RegPenaltyPerFlit: cfg_d.penalty_per_flit = cfg_data_i[CfgWordW-1:0];
        RegCreditPerTick:  cfg_d.credit_per_tick = cfg_data_i[CfgWordW-1:0];
        RegFlitsMinusOne:  cfg_d.flits_per_packet_minus_one = cfg_data_i[FlitCntW-1:0];
        RegFinalKeepMask:  cfg_d.final_keep_mask = cfg_data_i[MaskW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.penalty_per_flit           <= '0;
      cfg_q.credit_per_tick            <= CreditReset;
      cfg_q.flits_per_packet_minus_one <= '0;
      cfg_q.final_keep_mask            <= '1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/tpg_core.sv
// ----------------------------------------------------------------------------
// tpg_core
// Leaky-bucket throttle and packet state; decides and forms at most one flit a tick.
// ----------------------------------------------------------------------------
module tpg_core #(
  parameter int KEEP_BITS    = 64,
  parameter int PENALTY_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tpg_pkg::tpg_cfg_t            cfg_i,
  input  logic                         step_i,
  input  logic                         sink_ready_i,
  output logic                         flit_valid_o,
  output logic                         flit_last_o,
  output logic [KEEP_BITS-1:0]         flit_keep_o,
  output logic [tpg_pkg::PktCntW-1:0]  packet_index_o,
  output logic [tpg_pkg::PktCntW-1:0]  packets_sent_o
);
  import tpg_pkg::*;

  // compare width covers both the accumulator and the 32-bit config words
  localparam int CmpW = ((PENALTY_BITS > CfgWordW) ? PENALTY_BITS : CfgWordW) + 1;

  logic [PENALTY_BITS-1:0] acc_q, acc_d;
  logic [FlitCntW-1:0]     flit_cnt_q, flit_cnt_d;
  logic [PktCntW-1:0]      pkt_cnt_q, pkt_cnt_d;
  logic                    in_packet_q, in_packet_d;

  logic [CmpW-1:0] acc_ext, credit_ext, sum_ext, drain_ext, acc_max_ext;
  logic            below_credit, send, last_flit;

  always_comb begin
    acc_ext      = CmpW'(acc_q);
    credit_ext   = CmpW'(cfg_i.credit_per_tick);
    acc_max_ext  = CmpW'({PENALTY_BITS{1'b1}});
    sum_ext      = acc_ext + CmpW'(cfg_i.penalty_per_flit);
    drain_ext    = acc_ext - credit_ext;
    below_credit = acc_ext < credit_ext;
    send         = sink_ready_i && (in_packet_q || below_credit);
    last_flit    = flit_cnt_q >= cfg_i.flits_per_packet_minus_one;
  end

  always_comb begin
    acc_d       = acc_q;
    flit_cnt_d  = flit_cnt_q;
    pkt_cnt_d   = pkt_cnt_q;
    in_packet_d = in_packet_q;
    if (step_i) begin
      if (send) begin
        // saturate rather than wrap
        acc_d = (sum_ext > acc_max_ext) ? {PENALTY_BITS{1'b1}}
                                        : sum_ext[PENALTY_BITS-1:0];
        if (last_flit) begin
          in_packet_d = 1'b0;
          flit_cnt_d  = '0;
          pkt_cnt_d   = pkt_cnt_q + PktCntW'(1);
        end else begin
          in_packet_d = 1'b1;
          flit_cnt_d  = flit_cnt_q + FlitCntW'(1);
        end
      end else begin
        // idle tick drains the bucket, floored at zero
        acc_d = below_credit ? '0 : drain_ext[PENALTY_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      flit_cnt_q  <= '0;
      pkt_cnt_q   <= '0;
      in_packet_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      flit_cnt_q  <= flit_cnt_d;
      pkt_cnt_q   <= pkt_cnt_d;
      in_packet_q <= in_packet_d;
    end
  end

  always_comb begin
    flit_valid_o   = send;
    flit_last_o    = send && last_flit;
    flit_keep_o    = '0;
    packet_index_o = '0;
    if (send) begin
      flit_keep_o    = last_flit ? cfg_i.final_keep_mask[KEEP_BITS-1:0]
                                 : {KEEP_BITS{1'b1}};
      packet_index_o = pkt_cnt_q;
    end
    packets_sent_o = pkt_cnt_q;
  end

  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_packet_q |-> flit_cnt_q == '0)
    else $error("flit counter non-zero outside a packet");

  a_last_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && send && last_flit |=> !in_packet_q && pkt_cnt_q == $past(pkt_cnt_q) + 1'b1)
    else $error("last flit did not close the packet");

  a_idle_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !send |=> acc_q <= $past(acc_q) && pkt_cnt_q == $past(pkt_cnt_q))
    else $error("idle tick raised the accumulator or counted a packet");

endmodule

// File: sv/tpg_skid.sv
// ----------------------------------------------------------------------------
// tpg_skid
// Two-entry output buffer: result register plus skid register.
// ----------------------------------------------------------------------------
module tpg_skid #(
  parameter int DataW = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [DataW-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [DataW-1:0] out_data_o
);
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic [DataW-1:0] out_data_q, out_data_d;
  logic [DataW-1:0] skid_data_q, skid_data_d;
  logic             in_take, out_free;

  assign in_ready_o = !skid_valid_q;
  assign in_take    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d   = out_data_q;
    skid_data_d  = skid_data_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_take;
        out_data_d  = in_data_i;
      end
    end else if (in_take) begin
      // result register stalled: park the word
      skid_valid_d = 1'b1;
      skid_data_d  = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty result register");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_o && !out_ready_i))
    else $error("skid filled without a stalled result");

endmodule

// File: sv/throttled_packet_generator.sv
// ----------------------------------------------------------------------------
// throttled_packet_generator
// Leaky-bucket rate-limited stream source: one result word per tick word.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  item_in   in   valid/ready    sink_ready
//  flit_out  out  valid/ready    flit_valid, flit_last, flit_keep,
//                                packet_index, packets_sent
//  cfg       in   cfg_we_i       cfg_idx_i, cfg_data_i (no read-back)
//
//  one tick word is taken per clock while item_in.ready is high; its result
//  goes to the result register, or to the skid register while that is stalled.
//  a two-entry output buffer lets one more tick be taken after the
//  output stalls; item_in.ready drops only while both entries are full.
//  reset (rst_ni, asynchronous) empties the buffer and clears the bucket,
//  counters and packet flag; config returns to its reset values.
// ----------------------------------------------------------------------------
module throttled_packet_generator #(
  parameter int KEEP_BITS    = 64,
  parameter int PENALTY_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tpg_in_if.sink                        item_in,
  tpg_out_if.source                     flit_out,
  input  logic                          cfg_we_i,
  input  logic [tpg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tpg_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tpg_pkg::*;

  localparam int ResW = 2 + KEEP_BITS + 2 * PktCntW;

  tpg_cfg_t             cfg;
  logic                 step;
  logic                 res_valid, res_last;
  logic [KEEP_BITS-1:0] res_keep;
  logic [PktCntW-1:0]   res_index, res_sent;
  logic [ResW-1:0]      res_word, out_word;

  tpg_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign step = item_in.valid && item_in.ready;

  tpg_core #(
    .KEEP_BITS    (KEEP_BITS),
    .PENALTY_BITS (PENALTY_BITS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .step_i         (step),
    .sink_ready_i   (item_in.sink_ready),
    .flit_valid_o   (res_valid),
    .flit_last_o    (res_last),
    .flit_keep_o    (res_keep),
    .packet_index_o (res_index),
    .packets_sent_o (res_sent)
  );

  assign res_word = {res_valid, res_last, res_keep, res_index, res_sent};

  tpg_skid #(
    .DataW (ResW)
  ) u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_in.valid),
    .in_ready_o  (item_in.ready),
    .in_data_i   (res_word),
    .out_valid_o (flit_out.valid),
    .out_ready_i (flit_out.ready),
    .out_data_o  (out_word)
  );

  assign {flit_out.flit_valid, flit_out.flit_last, flit_out.flit_keep,
          flit_out.packet_index, flit_out.packets_sent} = out_word;

endmodule
